[src/bit_string_field_access_assert.svh]
// assertion macros for the bit string field access rtl
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef BIT_STRING_FIELD_ACCESS_ASSERT_SVH
`define BIT_STRING_FIELD_ACCESS_ASSERT_SVH

// same-cycle implication, off during reset
`define BSFA_ASSERT_NOW(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("bsfa assertion failed");

// next-cycle implication, off during reset
`define BSFA_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("bsfa assertion failed");

`endif

[src/bsfa_pkg.sv]
// shared types and constants for the bit string field access block
// no dependencies
package bsfa_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FILL  = 2'd2,
        OP_COUNT = 2'd3
    } t_op;

    localparam logic [1:0] CFG_STRING_LENGTH = 2'd0;
    localparam logic [1:0] CFG_BIT_OFFSET    = 2'd1;
    localparam int         CFG_IDX_W         = 2;
    localparam int         CFG_DATA_W        = 11;
    localparam logic [10:0] STRING_LENGTH_RST = 11'd1024;

    typedef struct packed {
        logic [1:0]  operation;
        logic [9:0]  position;
        logic [10:0] length;
        logic [63:0] value;
        logic [6:0]  pattern_length;
    } t_cmd;

    typedef struct packed {
        logic [63:0] data;
        logic        error;
    } t_result;

    // per-byte control handed to the lane
    typedef struct packed {
        t_op        op;
        logic [5:0] widx;
        logic [5:0] pidx;
        logic [6:0] plen;
    } t_lane_ctl;

    // bit indexes after the byte, carried to the next one
    typedef struct packed {
        logic [5:0] widx;
        logic [5:0] pidx;
    } t_lane_ret;

endpackage

[src/bit_string_field_access.sv]
// Bit string field access. After reset the block clears its store, one byte
// per cycle, with o_busy high.
// An operation then walks the store bytes touched by its range in a single
// read-modify-write pass through the byte ram.
// Rejected requests and zero-length counts skip that pass, with the result
// showing in the cycle right after start.
// The result shows for exactly one cycle with o_done and cannot be held off.
// Depends on bsfa_pkg, bsfa_mem, bsfa_lane and the assertion macro header.
module bit_string_field_access #(
    parameter int STORE_BITS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  bsfa_pkg::t_cmd                   i_cmd,
    output logic                             o_busy,
    output logic                             o_done,
    output bsfa_pkg::t_result                o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bsfa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bsfa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bsfa_pkg::*;
    `include "bit_string_field_access_assert.svh"

    localparam int DEPTH = (STORE_BITS + 7) / 8;
    localparam int BAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = ($clog2(STORE_BITS) > 11) ? ($clog2(STORE_BITS) + 1) : 13;
    localparam logic [EW-1:0]  STORE_LIMIT = EW'(STORE_BITS);
    localparam logic [BAW-1:0] LAST_ADDR   = BAW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_CLR  = 4'b0001,
        S_IDLE = 4'b0010,
        S_RUN  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [BAW-1:0] r_addr, n_addr;
    logic [BAW-1:0] r_last, n_last;
    logic [EW-1:0]  r_first, n_first;
    logic [EW-1:0]  r_end, n_end;
    t_lane_ctl     r_ctl, n_ctl;
    logic [63:0]   r_val, n_val;
    logic [63:0]   r_data, n_data;
    logic [EW-1:0]  r_cnt, n_cnt;
    t_result       r_res, n_res;
    logic [10:0]   r_slen;
    logic [9:0]    r_offset;

    logic          w_accept, w_err, w_nop, w_run_last;
    logic [EW-1:0]  w_first, w_end;
    logic [11:0]   w_str_end;
    logic          mem_we, mem_re;
    logic [BAW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;
    logic [7:0]    lane_byte;
    logic [63:0]   lane_data;
    logic [EW-1:0]  lane_cnt;
    t_lane_ret     lane_ret;

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = (r_state == S_DONE);
    assign o_result    = r_res;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start && !o_busy;

    // request checks
    always_comb begin
        logic len_bad;
        w_first   = EW'(r_offset) + EW'(i_cmd.position);
        w_end     = w_first + EW'(i_cmd.length);
        w_str_end = 12'(i_cmd.position) + 12'(i_cmd.length);
        len_bad   = (i_cmd.length == 11'd0) || (i_cmd.length > 11'd64);
        w_err     = (w_str_end > 12'(r_slen)) || (w_end > STORE_LIMIT);
        if ((i_cmd.operation == OP_READ || i_cmd.operation == OP_WRITE) && len_bad) begin
            w_err = 1'b1;
        end
        if (i_cmd.operation == OP_FILL && (i_cmd.length == 11'd0 ||
            i_cmd.pattern_length == 7'd0 || i_cmd.pattern_length > 7'd64)) begin
            w_err = 1'b1;
        end
        w_nop = w_err || (i_cmd.length == 11'd0);
    end

    assign w_run_last = (r_addr == r_last);

    bsfa_mem #(.DEPTH(DEPTH), .AW(BAW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bsfa_lane #(.EW(EW)) u_lane (
        .i_byte  (mem_rdata),
        .i_base  (EW'({r_addr, 3'b000})),
        .i_first (r_first),
        .i_end   (r_end),
        .i_ctl   (r_ctl),
        .i_value (r_val),
        .i_data  (r_data),
        .i_cnt   (r_cnt),
        .o_byte  (lane_byte),
        .o_data  (lane_data),
        .o_cnt   (lane_cnt),
        .o_ret   (lane_ret)
    );

    // the write of one byte and the read of the next never share an address
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = lane_byte;
        mem_re    = 1'b0;
        mem_raddr = r_addr + 1'b1;
        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_wdata = 8'd0;
            end
            S_IDLE: begin
                mem_re    = w_accept && !w_nop;
                mem_raddr = w_first[BAW+2:3];
            end
            S_RUN: begin
                mem_we = (r_ctl.op == OP_WRITE) || (r_ctl.op == OP_FILL);
                mem_re = !w_run_last;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_comb begin
        logic [EW-1:0] last_bit;
        n_state  = r_state;
        n_addr   = r_addr;
        n_last   = r_last;
        n_first  = r_first;
        n_end    = r_end;
        n_ctl    = r_ctl;
        n_val    = r_val;
        n_data   = r_data;
        n_cnt    = r_cnt;
        n_res    = r_res;
        last_bit = w_end - EW'(1);
        unique case (r_state)
            S_CLR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_first   = w_first;
                    n_end     = w_end;
                    n_addr    = w_first[BAW+2:3];
                    n_last    = last_bit[BAW+2:3];
                    n_ctl.op  = t_op'(i_cmd.operation);
                    n_ctl.widx = 6'd63;
                    n_ctl.pidx = 6'(i_cmd.pattern_length - 7'd1);
                    n_ctl.plen = i_cmd.pattern_length;
                    n_val     = i_cmd.value;
                    n_data    = 64'd0;
                    n_cnt     = '0;
                    n_res.data  = 64'd0;
                    n_res.error = w_err;
                    n_state   = w_nop ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                n_data     = lane_data;
                n_cnt      = lane_cnt;
                n_ctl.widx = lane_ret.widx;
                n_ctl.pidx = lane_ret.pidx;
                n_addr     = r_addr + 1'b1;
                if (w_run_last) begin
                    priority if (r_ctl.op == OP_READ) begin
                        n_res.data = lane_data;
                    end else if (r_ctl.op == OP_COUNT) begin
                        n_res.data = 64'(lane_cnt);
                    end else begin
                        n_res.data = 64'd0;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_addr   <= '0;
            r_slen   <= STRING_LENGTH_RST;
            r_offset <= 10'd0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_STRING_LENGTH) begin
                    r_slen <= i_cfg_data[10:0];
                end else if (i_cfg_index == CFG_BIT_OFFSET) begin
                    r_offset <= i_cfg_data[9:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last  <= n_last;
        r_first <= n_first;
        r_end   <= n_end;
        r_ctl   <= n_ctl;
        r_val   <= n_val;
        r_data  <= n_data;
        r_cnt   <= n_cnt;
        r_res   <= n_res;
    end

    `BSFA_ASSERT_NOW(a_err_zero_data, o_done && o_result.error, o_result.data == 64'd0)
    `BSFA_ASSERT_NEXT(a_bad_len_rejected, w_accept && i_cmd.length == 11'd0 && i_cmd.operation == OP_READ, o_done && o_result.error)
    `BSFA_ASSERT_NOW(a_no_write_idle, r_state == S_IDLE || r_state == S_DONE, !mem_we)
    `BSFA_ASSERT_NOW(a_run_in_range, r_state == S_RUN, r_addr <= r_last)
endmodule

[src/bsfa_mem.sv]
// byte-wide simple dual port ram, one write and one registered read port
// no dependencies
module bsfa_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[src/bsfa_lane.sv]
// modifies one stored byte for the current operation, gathers read bits and counts set bits
// depends on bsfa_pkg
module bsfa_lane #(
    parameter int EW = 13
) (
    input  logic [7:0]        i_byte,
    input  logic [EW-1:0]     i_base,
    input  logic [EW-1:0]     i_first,
    input  logic [EW-1:0]     i_end,
    input  bsfa_pkg::t_lane_ctl i_ctl,
    input  logic [63:0]       i_value,
    input  logic [63:0]       i_data,
    input  logic [EW-1:0]     i_cnt,
    output logic [7:0]        o_byte,
    output logic [63:0]       o_data,
    output logic [EW-1:0]     o_cnt,
    output bsfa_pkg::t_lane_ret o_ret
);
    import bsfa_pkg::*;

    always_comb begin
        logic [EW-1:0] abs_bit;
        logic          in_rng;
        logic [5:0]    widx;
        logic [5:0]    pidx;
        o_byte = i_byte;
        o_data = i_data;
        o_cnt  = i_cnt;
        widx   = i_ctl.widx;
        pidx   = i_ctl.pidx;
        // k = 0 is the most significant bit of the byte
        for (int k = 0; k < 8; k++) begin
            abs_bit = i_base + EW'(k);
            in_rng  = (abs_bit >= i_first) && (abs_bit < i_end);
            if (in_rng) begin
                unique case (i_ctl.op)
                    OP_READ: begin
                        o_data = {o_data[62:0], i_byte[7-k]};
                    end
                    OP_WRITE: begin
                        o_byte[7-k] = i_value[widx];
                        widx = widx - 6'd1;
                    end
                    OP_FILL: begin
                        o_byte[7-k] = i_value[pidx];
                        pidx = (pidx == 6'd0) ? 6'(i_ctl.plen - 7'd1) : pidx - 6'd1;
                    end
                    OP_COUNT: begin
                        o_cnt = o_cnt + EW'(i_byte[7-k]);
                    end
                    default: ;
                endcase
            end
        end
        o_ret.widx = widx;
        o_ret.pidx = pidx;
    end
endmodule

[bench/testbench.sv]
// testbench for bit_string_field_access: directed and random commands checked
// against a behavioral bit store kept in a scoreboard class
// depends on bsfa_pkg and the bit_string_field_access rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bsfa_pkg::*;

    localparam int STORE_BITS = 1024;
    localparam int LIMIT_CYCLES = 600000;

    class field_scoreboard;
        bit store [STORE_BITS];
        int unsigned str_len;
        int unsigned str_off;
        t_result pending [$];
        int errors;

        function new();
            foreach (store[k]) store[k] = 1'b0;
            str_len = 1024;
            str_off = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [10:0] data);
            if (idx == CFG_STRING_LENGTH) str_len = data;
            else if (idx == CFG_BIT_OFFSET) str_off = data[9:0];
        endfunction

        // apply one command to the bit store and queue its result
        function void note_cmd(t_cmd c);
            t_result r;
            int unsigned first;
            int unsigned n;
            int unsigned pl;
            bit bad;
            r = '0;
            first = str_off + c.position;
            n = c.length;
            pl = c.pattern_length;
            bad = (c.position + n > str_len) || (first + n > STORE_BITS);
            if ((c.operation == OP_READ || c.operation == OP_WRITE) && (n == 0 || n > 64))
                bad = 1;
            if (c.operation == OP_FILL && (n == 0 || pl == 0 || pl > 64))
                bad = 1;
            if (bad) begin
                r.error = 1'b1;
            end else begin
                for (int unsigned k = 0; k < n; k++) begin
                    case (c.operation)
                        OP_READ: r.data = {r.data[62:0], store[first+k]};
                        OP_WRITE: store[first+k] = c.value[63-k];
                        OP_FILL: store[first+k] = c.value[pl-1-(k%pl)];
                        default: r.data = r.data + store[first+k];
                    endcase
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result data=%h error=%b", $time, got.data, got.error);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.data !== want.data) begin
                $display("%0t: data mismatch expected %h actual %h", $time, want.data, got.data);
                errors++;
            end
            if (got.error !== want.error) begin
                $display("%0t: error mismatch expected %b actual %b", $time, want.error,
                         got.error);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_start, i_cfg_valid;
    t_cmd i_cmd;
    logic o_busy, o_done, o_cfg_ready;
    t_result o_result;
    logic [1:0] i_cfg_index;
    logic [10:0] i_cfg_data;
    int unsigned cycles;
    int unsigned n_cmds;
    field_scoreboard sb;

    bit_string_field_access #(.STORE_BITS(STORE_BITS)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_cmd(i_cmd),
        .o_busy(o_busy), .o_done(o_done), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_done) sb.check_result(o_result);
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic idle_gap();
        int unsigned g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) g = 0;
        repeat (g) @(negedge i_clk);
    endtask

    // drive on a fresh falling edge so start never gets two updates at once
    task automatic send_cmd(t_cmd c);
        @(negedge i_clk);
        i_cmd <= c;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        sb.note_cmd(c);
        n_cmds++;
        @(negedge i_clk);
        i_start <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] data);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_cmd make_cmd(t_op op, int unsigned pos, int unsigned len,
                                      logic [63:0] val, int unsigned pl);
        t_cmd c;
        c.operation = op;
        c.position = 10'(pos);
        c.length = 11'(len);
        c.value = val;
        c.pattern_length = 7'(pl);
        return c;
    endfunction

    // mostly valid commands with short ranges, some long and some broken
    function automatic t_cmd rand_cmd();
        t_cmd c;
        int unsigned lim;
        c.operation = t_op'($urandom_range(0, 3));
        c.value = {$urandom(), $urandom()};
        c.pattern_length = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(0, 127))
                                                        : 7'($urandom_range(1, 64));
        lim = (sb.str_len < 1024) ? sb.str_len : 1024;
        if ($urandom_range(0, 9) == 0) begin
            c.position = 10'($urandom());
            c.length = 11'($urandom());
        end else begin
            if (c.operation == OP_READ || c.operation == OP_WRITE)
                c.length = 11'($urandom_range(1, 64));
            else if ($urandom_range(0, 9) == 0)
                c.length = 11'($urandom_range(0, 1024));
            else
                c.length = 11'($urandom_range(0, 96));
            if (c.length > lim) c.length = 11'(lim);
            c.position = 10'($urandom_range(0, lim - c.length));
        end
        return c;
    endfunction

    initial begin
        cycles = 0;
        n_cmds = 0;
        sb = new();
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_cmd(make_cmd(OP_COUNT, 0, 1024, 0, 1));
        send_cmd(make_cmd(OP_FILL, 0, 1024, 64'h5, 3));
        send_cmd(make_cmd(OP_COUNT, 0, 1024, 0, 1));
        send_cmd(make_cmd(OP_WRITE, 0, 64, 64'hFFFF_0000_A5A5_1234, 1));
        send_cmd(make_cmd(OP_READ, 0, 64, 0, 1));
        send_cmd(make_cmd(OP_WRITE, 1023, 1, 64'h8000_0000_0000_0000, 1));
        send_cmd(make_cmd(OP_READ, 1023, 1, 0, 1));
        send_cmd(make_cmd(OP_READ, 960, 64, 0, 1));
        send_cmd(make_cmd(OP_READ, 5, 0, 0, 1));
        send_cmd(make_cmd(OP_WRITE, 5, 65, '1, 1));
        send_cmd(make_cmd(OP_READ, 1000, 25, 0, 1));
        send_cmd(make_cmd(OP_COUNT, 100, 0, 0, 1));
        send_cmd(make_cmd(OP_FILL, 10, 100, '1, 0));
        send_cmd(make_cmd(OP_FILL, 10, 100, '1, 65));
        send_cmd(make_cmd(OP_FILL, 3, 130, {$urandom(), $urandom()}, 64));
        send_cmd(make_cmd(OP_FILL, 200, 0, '1, 8));
        send_cmd(make_cmd(OP_COUNT, 1023, 2, 0, 1));
        send_cmd(make_cmd(OP_READ, 3, 64, 0, 1));
        send_cmd(make_cmd(OP_WRITE, 700, 13, '0, 1));
        send_cmd(make_cmd(OP_FILL, 7, 1, 64'h1, 1));
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_STRING_LENGTH, 11'd0);
                    write_reg(CFG_BIT_OFFSET, 11'd0);
                end
                1: begin
                    write_reg(CFG_STRING_LENGTH, 11'd2047);
                    write_reg(CFG_BIT_OFFSET, 11'd1023);
                end
                2: begin
                    write_reg(CFG_STRING_LENGTH, 11'd1);
                    write_reg(CFG_BIT_OFFSET, 11'd513);
                end
                3: begin
                    write_reg(CFG_STRING_LENGTH, 11'd1024);
                    write_reg(CFG_BIT_OFFSET, 11'd0);
                end
                default: begin
                    write_reg(CFG_STRING_LENGTH, 11'($urandom_range(1, 2047)));
                    write_reg(CFG_BIT_OFFSET, 11'($urandom_range(0, 1023)));
                end
            endcase
            // the first three settings accept nearly nothing, keep them short
            for (int k = 0; k < ((phase < 3) ? 15 : 70); k++) begin
                idle_gap();
                send_cmd(rand_cmd());
            end
            drain();
        end

        $display("ran %0d commands over 9 register settings, reads, writes, fills, counts",
                 n_cmds);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
